### sv/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg: shared types and constants of the pool free-list allocator
// Field widths, register reset values, request/status codes, controller
// state type and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int SLOTS_DEF  = 64;

  localparam int REQ_W      = 2;
  localparam int SLOT_W     = 6;
  localparam int ADDR_W     = 32;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = 7;
  localparam int BASE_W     = 32;
  localparam int BYTES_W    = 24;
  localparam int SBYTES_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0]    SLOT_COUNT_RST  = 7'd64;
  localparam logic [BASE_W-1:0]   BLOCK_BASE_RST  = 32'd0;
  localparam logic [BYTES_W-1:0]  BLOCK_BYTES_RST = 24'd4096;
  localparam logic [SBYTES_W-1:0] SLOT_BYTES_RST  = 16'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CHECK   = 2'd2,
    REQ_REINIT  = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY_REL = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT  = 2'd0,
    REG_BLOCK_BASE  = 2'd1,
    REG_BLOCK_BYTES = 2'd2,
    REG_SLOT_BYTES  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP
  } state_t;

  typedef struct packed {
    logic load_req;    // capture request fields
    logic exec_op;     // carry out allocate / release / check, load result
    logic sweep_init;  // restart the chain rebuild from slot 0
    logic sweep_en;    // write one chain entry
    logic res_reinit;  // load the reinitialize result
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_reinit;  // captured request is a reinitialize
    logic sweep_last;  // rebuild is at the last entry
  } dp_stat_t;

endpackage

### sv/pfla_ram.sv
// ----------------------------------------------------------------------------
// pfla_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/pfla_dp.sv
// ----------------------------------------------------------------------------
// pfla_dp: allocator datapath
// Config registers, request capture, head pointer, in-use count, the
// next-slot RAM with its rebuild counter, and the result registers.
// ----------------------------------------------------------------------------
module pfla_dp #(
  parameter int SLOTS = pfla_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pfla_pkg::ctrl_cmd_t             cmd,
  output pfla_pkg::dp_stat_t              stat,
  input  logic [pfla_pkg::REQ_W-1:0]      req_type,
  input  logic [pfla_pkg::SLOT_W-1:0]     slot,
  input  logic [pfla_pkg::ADDR_W-1:0]     address,
  input  logic                            cfg_we,
  input  logic [pfla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfla_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [pfla_pkg::STAT_W-1:0]     status,
  output logic [pfla_pkg::SLOT_W-1:0]     slot_index,
  output logic [pfla_pkg::ADDR_W-1:0]     slot_address,
  output logic                            in_block,
  output logic                            beyond_end,
  output logic [pfla_pkg::CNT_W-1:0]      in_use,
  output logic                            full_res
);

  import pfla_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int CW = (PW > CNT_W) ? PW : CNT_W;
  localparam logic [CW-1:0] END_MARK = CW'(SLOTS);

  // config registers
  logic [CNT_W-1:0]    slot_count;
  logic [BASE_W-1:0]   block_base;
  logic [BYTES_W-1:0]  block_bytes;
  logic [SBYTES_W-1:0] slot_bytes;

  // captured request
  req_t              req_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ADDR_W-1:0] address_q;

  // pool state
  logic [PW-1:0]    head;
  logic [CNT_W-1:0] used_count;
  logic [AW-1:0]    sw_cnt;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;

  logic [CW-1:0] sc_cw, n_eff, head_cw, used_cw, slot_cw, sw_nxt, sw_val;
  logic [PW+SBYTES_W-1:0] prod;
  logic [ADDR_W:0]        blk_end;
  logic [ADDR_W:0]        addr_ext;

  status_t           status_next;
  logic [SLOT_W-1:0] idx_next;
  logic [ADDR_W-1:0] saddr_next;
  logic              inb_next;
  logic              beyond_next;
  logic [PW-1:0]     head_next;
  logic [CNT_W-1:0]  used_next;
  logic              rel_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= SLOT_COUNT_RST;
      block_base  <= BLOCK_BASE_RST;
      block_bytes <= BLOCK_BYTES_RST;
      slot_bytes  <= SLOT_BYTES_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SLOT_COUNT:  slot_count  <= cfg_wdata[CNT_W-1:0];
        REG_BLOCK_BASE:  block_base  <= cfg_wdata[BASE_W-1:0];
        REG_BLOCK_BYTES: block_bytes <= cfg_wdata[BYTES_W-1:0];
        REG_SLOT_BYTES:  slot_bytes  <= cfg_wdata[SBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q     <= req_t'(req_type);
      slot_q    <= slot;
      address_q <= address;
    end
  end

  // effective slot count saturates at the RAM depth
  assign sc_cw   = CW'(slot_count);
  assign n_eff   = (sc_cw > END_MARK) ? END_MARK : sc_cw;
  assign head_cw = CW'(head);
  assign used_cw = CW'(used_count);
  assign slot_cw = CW'(slot_q);

  assign prod     = head * slot_bytes;
  assign blk_end  = {1'b0, block_base} + (ADDR_W + 1)'(block_bytes);
  assign addr_ext = {1'b0, address_q};

  always_comb begin
    status_next = ST_OK;
    idx_next    = '0;
    saddr_next  = '0;
    inb_next    = 1'b0;
    beyond_next = 1'b0;
    head_next   = head;
    used_next   = used_count;
    rel_write   = 1'b0;
    case (req_q)
      REQ_ALLOC: begin
        // a head past the pool end (broken chain) also reads as full
        if (used_cw >= n_eff || head_cw >= n_eff) begin
          status_next = ST_FULL;
        end else begin
          idx_next   = head_cw[SLOT_W-1:0];
          saddr_next = block_base + ADDR_W'(prod);
          head_next  = ram_rdata;
          used_next  = used_count + CNT_W'(1);
        end
      end
      REQ_RELEASE: begin
        if (used_count == '0) begin
          status_next = ST_EMPTY_REL;
        end else if (slot_cw >= n_eff) begin
          status_next = ST_RANGE;
        end else begin
          rel_write = 1'b1;
          head_next = slot_cw[PW-1:0];
          used_next = used_count - CNT_W'(1);
        end
      end
      REQ_CHECK: begin
        beyond_next = (addr_ext >= blk_end);
        inb_next    = (address_q >= block_base) && (addr_ext < blk_end);
      end
      default: ;
    endcase
  end

  // chain rebuild: entry i points at i+1, the tail at the end marker
  assign sw_nxt = CW'(sw_cnt) + CW'(1);
  assign sw_val = (sw_nxt < n_eff) ? sw_nxt : END_MARK;

  assign ram_we    = cmd.sweep_en | (cmd.exec_op & rel_write);
  assign ram_waddr = cmd.sweep_en ? sw_cnt : slot_cw[AW-1:0];
  assign ram_wdata = cmd.sweep_en ? sw_val[PW-1:0] : head;
  assign ram_raddr = head[AW-1:0];

  pfla_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_next_free (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_cnt <= '0;
    end else if (cmd.sweep_init) begin
      sw_cnt <= '0;
    end else if (cmd.sweep_en) begin
      sw_cnt <= sw_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      used_count <= '0;
    end else if (cmd.sweep_en) begin
      head       <= (n_eff != '0) ? '0 : END_MARK[PW-1:0];
      used_count <= '0;
    end else if (cmd.exec_op) begin
      head       <= head_next;
      used_count <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_op) begin
      status       <= status_next;
      slot_index   <= idx_next;
      slot_address <= saddr_next;
      in_block     <= inb_next;
      beyond_end   <= beyond_next;
      in_use       <= used_next;
      full_res     <= (CW'(used_next) >= n_eff);
    end else if (cmd.res_reinit) begin
      status       <= ST_OK;
      slot_index   <= '0;
      slot_address <= '0;
      in_block     <= 1'b0;
      beyond_end   <= 1'b0;
      in_use       <= '0;
      full_res     <= (n_eff == '0);
    end
  end

  assign stat.req_reinit = (req_q == REQ_REINIT);
  assign stat.sweep_last = (sw_cnt == AW'(SLOTS - 1));

endmodule

### sv/pfla_ctrl.sv
// ----------------------------------------------------------------------------
// pfla_ctrl: allocator controller
// Sequences request capture, execution and the chain rebuild; drives busy
// and the result strobe.
// ----------------------------------------------------------------------------
module pfla_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                cfg_restart,
  input  pfla_pkg::dp_stat_t  stat,
  output pfla_pkg::ctrl_cmd_t cmd,
  output logic                busy,
  output logic                done
);

  import pfla_pkg::*;

  state_t state, state_next;
  logic   pend, pend_next;  // reinitialize result owed at end of rebuild

  always_comb begin
    state_next = state;
    pend_next  = pend;
    case (state)
      S_IDLE: begin
        if (cfg_restart) begin
          state_next = S_SWEEP;
        end else if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.req_reinit) begin
          state_next = S_SWEEP;
          pend_next  = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (cfg_restart) begin
          pend_next = 1'b0;
        end else if (stat.sweep_last) begin
          state_next = S_IDLE;
          pend_next  = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (cfg_restart) begin
          cmd.sweep_init = 1'b1;
        end else if (start) begin
          cmd.load_req = 1'b1;
        end
      end
      S_EXEC: begin
        if (stat.req_reinit) begin
          cmd.sweep_init = 1'b1;
        end else begin
          cmd.exec_op = 1'b1;
        end
      end
      S_SWEEP: begin
        if (cfg_restart) begin
          cmd.sweep_init = 1'b1;
        end else begin
          cmd.sweep_en   = 1'b1;
          cmd.res_reinit = stat.sweep_last & pend;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;  // rebuild the chain out of reset
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      done  <= cmd.exec_op | cmd.res_reinit;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

### sv/pool_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// pool_free_list_allocator_unit: fixed-size pool allocator, linked free list
// Hands out and takes back equal-size slots, checks addresses against the
// block, and rebuilds the free chain on demand.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Payload
//  --------  ------------------  ---------------------------------------------
//  request   start & !busy       req_type, slot, address
//  result    done (1 cycle)      status, slot_index, slot_address, in_block,
//                                beyond_end, in_use, full_res
//  config    cfg_we              cfg_index, cfg_wdata
//
//  For allocate, release and address check, the accept cycle reads
//  the next-slot RAM at the head, the next cycle updates head and count and
//  loads the result, and done strobes the cycle after with busy already low.
//  Reinitialize runs the chain rebuild, one RAM entry per cycle; a slot_count
//  write restarts it and drops the result. After reset, and after a slot_count
//  write while idle, the same rebuild runs with busy high and no result. The
//  result is shown for one cycle only; the receiver cannot stall it.
//
module pool_free_list_allocator_unit #(
  parameter int SLOTS = pfla_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request
  input  logic                            start,
  output logic                            busy,
  input  logic [pfla_pkg::REQ_W-1:0]      req_type,
  input  logic [pfla_pkg::SLOT_W-1:0]     slot,
  input  logic [pfla_pkg::ADDR_W-1:0]     address,
  // result
  output logic                            done,
  output logic [pfla_pkg::STAT_W-1:0]     status,
  output logic [pfla_pkg::SLOT_W-1:0]     slot_index,
  output logic [pfla_pkg::ADDR_W-1:0]     slot_address,
  output logic                            in_block,
  output logic                            beyond_end,
  output logic [pfla_pkg::CNT_W-1:0]      in_use,
  output logic                            full_res,
  // config
  input  logic                            cfg_we,
  input  logic [pfla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfla_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import pfla_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      cfg_restart;

  // a new slot count rebuilds the pool (taken while idle or rebuilding)
  assign cfg_restart = cfg_we && (reg_idx_t'(cfg_index) == REG_SLOT_COUNT);

  pfla_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cfg_restart (cfg_restart),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done)
  );

  pfla_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .slot         (slot),
    .address      (address),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .status       (status),
    .slot_index   (slot_index),
    .slot_address (slot_address),
    .in_block     (in_block),
    .beyond_end   (beyond_end),
    .in_use       (in_use),
    .full_res     (full_res)
  );

  // an accepted request always keeps the unit busy the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // the result strobe only comes once the unit is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // a refused request carries no slot
  a_fail_noslot: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (slot_index == '0 && slot_address == '0))
    else $error("failed request returned a slot");

  // an address cannot be both inside the block and past its end
  a_check_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(in_block && beyond_end))
    else $error("address inside and beyond block");

endmodule

### tb/sv/pool_free_list_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// pool_free_list_allocator_unit_test: self-checking bench for the pool allocator
// Drives allocate, release, address-check and reinitialize requests through
// the start/busy port under several register settings, predicts every result
// with a cycle-free model of the free list, and checks each done strobe.
// ----------------------------------------------------------------------------
module pool_free_list_allocator_unit_test;
  import pfla_pkg::*;

  localparam int SLOT_LIMIT = SLOTS_DEF;
  localparam int SETTLE     = 4;          // cycles after a register write
  localparam int MAX_SHOWN  = 10;

  // one pending entry: either a request or a register write
  typedef struct {
    bit                    kind_cfg;
    reg_idx_t              ridx;
    logic [CFG_DATA_W-1:0] wdata;
    req_t                  op;
    logic [SLOT_W-1:0]     slot;
    logic [ADDR_W-1:0]     addr;
    bit                    from_pool;     // release a slot the pool handed out
    int                    gap;           // idle cycles after this entry
  } pool_stim_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [ADDR_W-1:0] slot_address;
    logic              in_block;
    logic              beyond_end;
    logic [CNT_W-1:0]  in_use;
    logic              full_res;
  } pool_result_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [REQ_W-1:0]      req_type = '0;
  logic [SLOT_W-1:0]     slot = '0;
  logic [ADDR_W-1:0]     address = '0;
  logic                  done;
  logic [STAT_W-1:0]     status;
  logic [SLOT_W-1:0]     slot_index;
  logic [ADDR_W-1:0]     slot_address;
  logic                  in_block;
  logic                  beyond_end;
  logic [CNT_W-1:0]      in_use;
  logic                  full_res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pool_free_list_allocator_unit uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .slot         (slot),
    .address      (address),
    .done         (done),
    .status       (status),
    .slot_index   (slot_index),
    .slot_address (slot_address),
    .in_block     (in_block),
    .beyond_end   (beyond_end),
    .in_use       (in_use),
    .full_res     (full_res),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  pool_stim_t   pending_q[$];     // requests and writes not yet driven
  pool_result_t expected_q[$];    // predicted results, oldest first
  logic [SLOT_W-1:0] held_slots[$];  // slots the model says are handed out

  bit req_taken = 1'b0;           // request accepted at the last rising edge
  int cfg_age   = 0;              // cycles since the last register write
  int gap_left  = 0;
  int gap_max   = 16;

  int fail_count = 0;
  int n_requests = 0;
  int n_results  = 0;
  int n_cfg      = 0;
  int n_granted  = 0;
  int n_refused  = 0;

  // register values the generator aims its addresses and bursts at
  logic [CNT_W-1:0]    g_count;
  logic [BASE_W-1:0]   g_base;
  logic [BYTES_W-1:0]  g_bytes;

  // --------------------------------------------------------------------------
  // Free-list model: registers, next-slot store, head, in-use count
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]    slot_cnt;
  logic [BASE_W-1:0]   blk_base;
  logic [BYTES_W-1:0]  blk_bytes;
  logic [SBYTES_W-1:0] slot_size;
  logic [CNT_W-1:0]    free_link[SLOT_LIMIT];
  logic [CNT_W-1:0]    free_head;
  logic [CNT_W-1:0]    slots_taken;

  // slot_count saturates at the pool depth
  function automatic logic [CNT_W-1:0] live_slots();
    return (slot_cnt > CNT_W'(SLOT_LIMIT)) ? CNT_W'(SLOT_LIMIT) : slot_cnt;
  endfunction

  // chain 0 -> 1 -> ... -> n-1 -> end marker (SLOT_LIMIT)
  task automatic rebuild_chain();
    logic [CNT_W-1:0] n;
    n = live_slots();
    for (int i = 0; i < SLOT_LIMIT; i++) begin
      free_link[i] = (i + 1 < n) ? CNT_W'(i + 1) : CNT_W'(SLOT_LIMIT);
    end
    free_head   = (n != 0) ? '0 : CNT_W'(SLOT_LIMIT);
    slots_taken = '0;
    held_slots.delete();
  endtask

  task automatic reset_pool_model();
    slot_cnt  = SLOT_COUNT_RST;
    blk_base  = BLOCK_BASE_RST;
    blk_bytes = BLOCK_BYTES_RST;
    slot_size = SLOT_BYTES_RST;
    rebuild_chain();
  endtask

  task automatic apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (reg_idx_t'(idx))
      REG_SLOT_COUNT: begin
        slot_cnt = data[CNT_W-1:0];
        rebuild_chain();              // a count write also rebuilds the pool
      end
      REG_BLOCK_BASE:  blk_base  = data[BASE_W-1:0];
      REG_BLOCK_BYTES: blk_bytes = data[BYTES_W-1:0];
      default:         slot_size = data[SBYTES_W-1:0];
    endcase
  endtask

  // result of one request, and the state change it causes
  task automatic predict_pool_response(input req_t op, input logic [SLOT_W-1:0] s,
                                       input logic [ADDR_W-1:0] a,
                                       output pool_result_t r);
    logic [CNT_W-1:0] n;
    logic [ADDR_W:0]  blk_end;
    int               hit;
    n   = live_slots();
    r   = '0;
    hit = -1;
    case (op)
      REQ_ALLOC: begin
        // a head past the pool (damaged chain) also reads as full
        if (slots_taken >= n || free_head >= n) begin
          r.status = ST_FULL;
        end else begin
          r.status       = ST_OK;
          r.slot_index   = free_head[SLOT_W-1:0];
          r.slot_address = blk_base + {25'd0, free_head} * {16'd0, slot_size};
          held_slots.push_back(free_head[SLOT_W-1:0]);
          free_head   = free_link[free_head[SLOT_W-1:0]];
          slots_taken = slots_taken + 1'b1;
        end
      end
      REQ_RELEASE: begin
        // empty check wins over the range check
        if (slots_taken == 0) begin
          r.status = ST_EMPTY_REL;
        end else if ({1'b0, s} >= n) begin
          r.status = ST_RANGE;
        end else begin
          r.status     = ST_OK;
          free_link[s] = free_head;
          free_head    = {1'b0, s};
          slots_taken  = slots_taken - 1'b1;
          for (int k = 0; k < held_slots.size(); k++) begin
            if (hit < 0 && held_slots[k] == s) hit = k;
          end
          if (hit >= 0) held_slots.delete(hit);
        end
      end
      REQ_CHECK: begin
        // end is 33 bits wide: a block running past 4 GiB is never passed
        blk_end      = {1'b0, blk_base} + {9'd0, blk_bytes};
        r.status     = ST_OK;
        r.beyond_end = ({1'b0, a} >= blk_end);
        r.in_block   = (a >= blk_base) && ({1'b0, a} < blk_end);
      end
      default: begin
        r.status = ST_OK;
        rebuild_chain();
      end
    endcase
    r.in_use   = slots_taken;
    r.full_res = (slots_taken >= n);
  endtask

  function automatic string show_result(pool_result_t r);
    return $sformatf("status=%0d slot=%0d addr=%08h in_block=%0b beyond=%0b in_use=%0d full=%0b",
                     r.status, r.slot_index, r.slot_address, r.in_block, r.beyond_end,
                     r.in_use, r.full_res);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic add_request(input req_t op, input logic [SLOT_W-1:0] s,
                             input logic [ADDR_W-1:0] a, input bit from_pool);
    pool_stim_t it;
    it.kind_cfg  = 1'b0;
    it.ridx      = REG_SLOT_COUNT;
    it.wdata     = '0;
    it.op        = op;
    it.slot      = s;
    it.addr      = a;
    it.from_pool = from_pool;
    it.gap       = $urandom_range(gap_max, 0);
    pending_q.push_back(it);
  endtask

  // writes all four registers in turn from a random first one; upper data bits carry noise
  task automatic add_phase_config(input logic [CNT_W-1:0] cnt,
                                  input logic [BASE_W-1:0] base,
                                  input logic [BYTES_W-1:0] bytes,
                                  input logic [SBYTES_W-1:0] sb);
    pool_stim_t            it;
    int                    first;
    logic [CFG_DATA_W-1:0] val;
    logic [CFG_DATA_W-1:0] mask;
    first   = $urandom_range(3);
    g_count = cnt;
    g_base  = base;
    g_bytes = bytes;
    for (int k = 0; k < 4; k++) begin
      it.kind_cfg  = 1'b1;
      it.op        = REQ_ALLOC;
      it.slot      = '0;
      it.addr      = '0;
      it.from_pool = 1'b0;
      it.ridx      = reg_idx_t'((first + k) % 4);
      case (it.ridx)
        REG_SLOT_COUNT:  begin val = {25'd0, cnt};  mask = 32'h0000_007F; end
        REG_BLOCK_BASE:  begin val = base;          mask = 32'hFFFF_FFFF; end
        REG_BLOCK_BYTES: begin val = {8'd0, bytes}; mask = 32'h00FF_FFFF; end
        default:         begin val = {16'd0, sb};   mask = 32'h0000_FFFF; end
      endcase
      it.wdata = (32'($urandom) & ~mask) | val;
      it.gap   = $urandom_range(gap_max, 0);
      pending_q.push_back(it);
    end
  endtask

  // alternating allocate and release bursts sized to the pool, with checks,
  // stray releases and the odd reinitialize mixed in
  task automatic random_traffic(input int budget);
    int               made;
    int               len;
    int               roll;
    int               n;
    bit               grow;
    logic [ADDR_W-1:0] a;
    n    = (g_count > CNT_W'(SLOT_LIMIT)) ? SLOT_LIMIT : int'(g_count);
    made = 0;
    grow = 1'b1;
    while (made < budget) begin
      len = $urandom_range(n + 2, 1);
      for (int k = 0; k < len && made < budget; k++) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          add_request(REQ_REINIT, SLOT_W'($urandom_range(63)), $urandom, 1'b0);
        end else if (roll < 12) begin
          case ($urandom_range(4))
            0:       a = g_base;
            1:       a = g_base + g_bytes - 1;
            2:       a = g_base + g_bytes;
            3:       a = g_base - 1;
            default: a = $urandom;
          endcase
          add_request(REQ_CHECK, SLOT_W'($urandom_range(63)), a, 1'b0);
        end else if (grow) begin
          add_request(REQ_ALLOC, SLOT_W'($urandom_range(63)), $urandom, 1'b0);
        end else begin
          // mostly a slot really held; the rest hits free or absent slots
          add_request(REQ_RELEASE, SLOT_W'($urandom_range(63)), $urandom, roll < 90);
        end
        made++;
      end
      grow = !grow;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: inputs move on the falling edge. start holds until the request
  // is taken; register writes wait until nothing is outstanding and the
  // block is idle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_p
    pool_stim_t it;
    logic       nx_start;
    logic       nx_we;
    nx_start = start;
    nx_we    = 1'b0;
    if (rst) begin
      nx_start = 1'b0;
    end else if (!start || req_taken) begin
      nx_start = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_q.size() != 0) begin
        it = pending_q[0];
        if (it.kind_cfg) begin
          if (expected_q.size() == 0 && busy === 1'b0 && cfg_age >= SETTLE) begin
            nx_we     = 1'b1;
            cfg_index <= it.ridx;
            cfg_wdata <= it.wdata;
            pending_q.delete(0);
            gap_left = it.gap;
          end
        end else if (cfg_age >= SETTLE) begin
          // a slot_count write starts a rebuild; give busy time to rise
          nx_start = 1'b1;
          req_type <= it.op;
          slot     <= (it.from_pool && held_slots.size() != 0) ?
                      held_slots[$urandom_range(held_slots.size() - 1)] : it.slot;
          address  <= it.addr;
          pending_q.delete(0);
          gap_left = it.gap;
        end
      end
    end
    start  <= nx_start;
    cfg_we <= nx_we;
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, predict each accepted request and check each
  // done strobe against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_p
    pool_result_t want;
    pool_result_t got;
    if (rst) begin
      reset_pool_model();
      expected_q.delete();
      req_taken <= 1'b0;
      cfg_age   <= 0;
    end else begin
      req_taken <= start && busy === 1'b0;
      if (cfg_we) begin
        apply_register_write(cfg_index, cfg_wdata);
        n_cfg++;
        cfg_age <= 0;
      end else if (cfg_age < 255) begin
        cfg_age <= cfg_age + 1;
      end
      if (start && busy === 1'b0) begin
        predict_pool_response(req_t'(req_type), slot, address, want);
        expected_q.push_back(want);
        n_requests++;
        if (req_t'(req_type) == REQ_ALLOC) begin
          if (want.status == ST_OK) n_granted++;
          else n_refused++;
        end
      end
      if (done === 1'b1) begin
        got = {status, slot_index, slot_address, in_block, beyond_end, in_use, full_res};
        n_results++;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("result with no request outstanding: %s",
                                 show_result(got)));
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            note_failure($sformatf("result %0d\n  expected %s\n  actual   %s",
                                   n_results, show_result(want), show_result(got)));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main_p
    logic [CNT_W-1:0]    cnt;
    logic [BASE_W-1:0]   base;
    logic [BYTES_W-1:0]  bytes;
    logic [SBYTES_W-1:0] sb;

    g_count = SLOT_COUNT_RST;
    g_base  = BLOCK_BASE_RST;
    g_bytes = BLOCK_BYTES_RST;

    // reset values: 64 slots of 64 bytes at 0, block of 4096 bytes
    gap_max = 3;
    add_request(REQ_RELEASE, 6'd63, 32'h0, 1'b0);          // release while empty
    add_request(REQ_ALLOC,   6'd0,  32'h0, 1'b0);
    add_request(REQ_ALLOC,   6'd0,  32'h0, 1'b0);
    add_request(REQ_CHECK,   6'd0,  32'h0000_0000, 1'b0);
    add_request(REQ_CHECK,   6'd0,  32'h0000_0FFF, 1'b0);
    add_request(REQ_CHECK,   6'd0,  32'h0000_1000, 1'b0);  // first byte past end
    add_request(REQ_CHECK,   6'd63, 32'hFFFF_FFFF, 1'b0);
    add_request(REQ_RELEASE, 6'd1,  32'h0, 1'b0);
    add_request(REQ_ALLOC,   6'd0,  32'h0, 1'b0);          // slot 1 comes back
    add_request(REQ_RELEASE, 6'd0,  32'h0, 1'b0);
    add_request(REQ_REINIT,  6'd0,  32'h0, 1'b0);
    add_request(REQ_ALLOC,   6'd0,  32'h0, 1'b0);

    // two slots, largest sizes, base near the top: addresses wrap and the
    // block end lies past 4 GiB
    add_phase_config(7'd2, 32'hFFFF_FF00, 24'hFF_FFFF, 16'hFFFF);
    add_request(REQ_ALLOC,   6'd0,  32'h0, 1'b0);
    add_request(REQ_ALLOC,   6'd0,  32'h0, 1'b0);
    add_request(REQ_ALLOC,   6'd0,  32'h0, 1'b0);          // pool full
    add_request(REQ_RELEASE, 6'd63, 32'h0, 1'b0);          // slot out of range
    add_request(REQ_RELEASE, 6'd1,  32'h0, 1'b0);
    add_request(REQ_CHECK,   6'd0,  32'hFFFF_FFFF, 1'b0);
    add_request(REQ_CHECK,   6'd0,  32'h0000_0000, 1'b0);

    // zero slots, smallest sizes: always full
    add_phase_config(7'd0, 32'h0, 24'd1, 16'd1);
    add_request(REQ_ALLOC,   6'd0,  32'h0, 1'b0);
    add_request(REQ_RELEASE, 6'd0,  32'h0, 1'b0);
    add_request(REQ_CHECK,   6'd0,  32'h0, 1'b0);
    add_request(REQ_CHECK,   6'd0,  32'h1, 1'b0);
    add_request(REQ_REINIT,  6'd0,  32'h0, 1'b0);

    // random phases; every third one runs without idle cycles
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: cnt = 7'd127;                                  // saturates to 64
        1: cnt = 7'd64;
        2: cnt = 7'd1;
        default: begin
          case ($urandom_range(4))
            0:       cnt = CNT_W'($urandom_range(4, 1));
            1:       cnt = CNT_W'($urandom_range(16, 5));
            2:       cnt = CNT_W'($urandom_range(63, 17));
            3:       cnt = CNT_W'($urandom_range(127, 65));
            default: cnt = ($urandom_range(3) == 0) ? 7'd0 : 7'd64;
          endcase
        end
      endcase
      case ($urandom_range(3))
        0:       base = 32'h0;
        1:       base = 32'hFFFF_FFFF - $urandom_range(65535);
        default: base = $urandom;
      endcase
      case ($urandom_range(3))
        0:       bytes = 24'd1;
        1:       bytes = 24'hFF_FFFF;
        default: bytes = BYTES_W'($urandom_range(24'hFF_FFFF, 1));
      endcase
      case ($urandom_range(3))
        0:       sb = 16'd1;
        1:       sb = 16'hFFFF;
        default: sb = SBYTES_W'($urandom_range(16'hFFFF, 1));
      endcase
      gap_max = (ph % 3 == 1) ? 0 : 16;
      add_phase_config(cnt, base, bytes, sb);
      random_traffic(55);
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk);
    // long enough for a full rebuild plus a stray strobe to show up
    repeat (2 * SLOT_LIMIT) @(posedge clk);

    $display("pool run: %0d requests, %0d results checked, %0d register writes",
             n_requests, n_results, n_cfg);
    $display("pool run: %0d allocations granted, %0d refused, %0d failures",
             n_granted, n_refused, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : limit_p
    #2000000;
    $display("timeout: %0d requests still waiting, %0d results outstanding",
             pending_q.size(), expected_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
sv/pfla_pkg.sv
sv/pfla_ram.sv
sv/pfla_dp.sv
sv/pfla_ctrl.sv
sv/pool_free_list_allocator_unit.sv
tb/sv/pool_free_list_allocator_unit_test.sv
